/* sv/bsr_pkg.sv */
// Shared types and constants of the brush stroke rasterizer.
// Used by the controller, the datapath, the top level and the checker.
package bsr_pkg;

  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_MOVE    = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_STARTED = 2'd1;
  localparam logic [1:0] EV_STOPPED = 2'd2;
  localparam logic [1:0] EV_DRAWN   = 2'd3;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_COLOUR = 1'b1;

  localparam logic [5:0]  RADIUS_RESET = 6'd20;
  localparam logic [31:0] COLOUR_RESET = 32'h0000_00FF;
  localparam logic [31:0] BLANK_COLOUR = 32'hFFFF_FF00;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_code;
    logic [31:0] pixel_colour;
    logic        pixel_marked;
    logic        box_valid;
    logic [8:0]  box_min_x;
    logic [8:0]  box_min_y;
    logic [8:0]  box_max_x;
    logic [8:0]  box_max_y;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_INIT_CLR, ST_IDLE, ST_CLEAR, ST_PREP, ST_CHECK, ST_SQRT,
    ST_DIVX_LD, ST_DIVX, ST_DIVY_LD, ST_DIVY, ST_LSETUP, ST_ROW,
    ST_LINE, ST_DISC_INIT, ST_DISC, ST_READ, ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic stamp;
    logic calc_l2;
    logic sq_start;
    logic sq_step;
    logic div_start;
    logic div_sel;
    logic div_step;
    logic line_setup;
    logic row_start;
    logic line_step;
    logic row_next;
    logic disc_init;
    logic disc_step;
    logic rd;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic in_inside;
    logic pen;
    logic line_go;
    logic it_last;
    logic row_end;
    logic row_last;
    logic disc_last;
    logic clr_last;
  } status_t;

endpackage

/* sv/bsr_ctrl.sv */
// Sequencer of the brush stroke rasterizer.
// Depends on bsr_pkg; drives the datapath through bsr_pkg::cmd_t.
module bsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        kind,
  input  bsr_pkg::status_t  st,
  output bsr_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              out_valid
);

  bsr_pkg::state_t state_r, state_nxt;
  logic stamp;

  always_comb begin
    stamp = st.in_inside &&
            ((kind == bsr_pkg::KIND_PRESS) || (kind == bsr_pkg::KIND_RELEASE) ||
             ((kind == bsr_pkg::KIND_MOVE) && st.pen));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsr_pkg::ST_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsr_pkg::ST_INIT_CLR: if (st.clr_last) state_nxt = bsr_pkg::ST_IDLE;
      bsr_pkg::ST_IDLE: begin
        if (start) begin
          if (kind inside {bsr_pkg::KIND_PRESS, bsr_pkg::KIND_RELEASE,
                           bsr_pkg::KIND_MOVE}) begin
            state_nxt = stamp ? bsr_pkg::ST_PREP : bsr_pkg::ST_DONE;
          end else if (kind == bsr_pkg::KIND_READ) begin
            state_nxt = bsr_pkg::ST_READ;
          end else if (kind == bsr_pkg::KIND_CLEAR) begin
            state_nxt = bsr_pkg::ST_CLEAR;
          end else begin
            state_nxt = bsr_pkg::ST_DONE;
          end
        end
      end
      bsr_pkg::ST_CLEAR:   if (st.clr_last) state_nxt = bsr_pkg::ST_DONE;
      bsr_pkg::ST_PREP:    state_nxt = bsr_pkg::ST_CHECK;
      bsr_pkg::ST_CHECK:
        state_nxt = st.line_go ? bsr_pkg::ST_SQRT : bsr_pkg::ST_DISC_INIT;
      bsr_pkg::ST_SQRT:    if (st.it_last) state_nxt = bsr_pkg::ST_DIVX_LD;
      bsr_pkg::ST_DIVX_LD: state_nxt = bsr_pkg::ST_DIVX;
      bsr_pkg::ST_DIVX:    if (st.it_last) state_nxt = bsr_pkg::ST_DIVY_LD;
      bsr_pkg::ST_DIVY_LD: state_nxt = bsr_pkg::ST_DIVY;
      bsr_pkg::ST_DIVY:    if (st.it_last) state_nxt = bsr_pkg::ST_LSETUP;
      bsr_pkg::ST_LSETUP:  state_nxt = bsr_pkg::ST_ROW;
      bsr_pkg::ST_ROW:     state_nxt = bsr_pkg::ST_LINE;
      bsr_pkg::ST_LINE: begin
        if (st.row_end) begin
          state_nxt = st.row_last ? bsr_pkg::ST_DISC_INIT : bsr_pkg::ST_ROW;
        end
      end
      bsr_pkg::ST_DISC_INIT: state_nxt = bsr_pkg::ST_DISC;
      bsr_pkg::ST_DISC:    if (st.disc_last) state_nxt = bsr_pkg::ST_DONE;
      bsr_pkg::ST_READ:    state_nxt = bsr_pkg::ST_DONE;
      bsr_pkg::ST_DONE:    state_nxt = bsr_pkg::ST_IDLE;
      default:             state_nxt = bsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      bsr_pkg::ST_INIT_CLR, bsr_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      bsr_pkg::ST_IDLE: begin
        cmd.accept = start;
        cmd.stamp  = start && stamp;
      end
      bsr_pkg::ST_PREP:  cmd.calc_l2 = 1'b1;
      bsr_pkg::ST_CHECK: cmd.sq_start = st.line_go;
      bsr_pkg::ST_SQRT:  cmd.sq_step = 1'b1;
      bsr_pkg::ST_DIVX_LD: cmd.div_start = 1'b1;
      bsr_pkg::ST_DIVX:  cmd.div_step = 1'b1;
      bsr_pkg::ST_DIVY_LD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      bsr_pkg::ST_DIVY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = 1'b1;
      end
      bsr_pkg::ST_LSETUP: cmd.line_setup = 1'b1;
      bsr_pkg::ST_ROW:    cmd.row_start = 1'b1;
      bsr_pkg::ST_LINE: begin
        cmd.line_step = !st.row_end;
        cmd.row_next  = st.row_end;
      end
      bsr_pkg::ST_DISC_INIT: cmd.disc_init = 1'b1;
      bsr_pkg::ST_DISC:  cmd.disc_step = 1'b1;
      bsr_pkg::ST_READ:  cmd.rd = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy      = (state_r != bsr_pkg::ST_IDLE);
  assign out_valid = (state_r == bsr_pkg::ST_DONE);

endmodule

/* sv/bsr_dp.sv */
// Datapath of the brush stroke rasterizer: canvas memory, pen and box state,
// square root and divider iterations, line and disc walkers. Depends on bsr_pkg.
module bsr_dp #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 256,
  parameter int MAX_RADIUS    = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsr_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  bsr_pkg::cmd_t       cmd,
  output bsr_pkg::status_t    st,
  output bsr_pkg::out_item_t  out_data
);

  localparam int W     = CANVAS_WIDTH;
  localparam int H     = CANVAS_HEIGHT;
  localparam int XW    = $clog2(W);
  localparam int YW    = $clog2(H);
  localparam int DEPTH = W * H;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (W > H) ? W : H;
  localparam int DW    = $clog2(MAXD);
  localparam int BW    = $clog2(MAXD + 1);
  localparam int L2W   = 2 * DW + 1;
  localparam int SW    = 2 * DW + 34;
  localparam int LQW   = SW / 2;
  localparam int NW    = DW + 33;
  localparam int ITW   = $clog2(NW);
  localparam int MW    = DW + 2;
  localparam int PW    = 32;
  localparam int NVW   = 20;
  localparam logic signed [PW-1:0] XLIM = PW'(W * 65536);
  localparam logic signed [PW-1:0] YLIM = PW'(H * 65536);

  // Configuration
  logic [5:0]  brush_r;
  logic [31:0] colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_r  <= bsr_pkg::RADIUS_RESET;
      colour_r <= bsr_pkg::COLOUR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsr_pkg::CFG_RADIUS: brush_r  <= cfg_wdata[5:0];
        bsr_pkg::CFG_COLOUR: colour_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [5:0] r_eff;
  assign r_eff = (8'(brush_r) > 8'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : brush_r;

  // Input decode
  logic in_inside;
  assign in_inside = !in_data.pos_x[11] && ({1'b0, in_data.pos_x} < 13'(W)) &&
                     !in_data.pos_y[11] && ({1'b0, in_data.pos_y} < 13'(H));

  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  assign in_x = in_data.pos_x[XW-1:0];
  assign in_y = in_data.pos_y[YW-1:0];

  // Pen, anchor, event registers
  logic          pen_r, anchor_valid_r, line_req_r, rdv_r;
  logic [XW-1:0] anchor_x_r, ev_x_r;
  logic [YW-1:0] anchor_y_r, ev_y_r;
  logic [1:0]    code_r;
  logic [5:0]    r_r;
  logic signed [DW:0] dx_r, dy_r;
  logic          pen_new;
  logic          is_ptr;

  assign is_ptr = (in_data.kind == bsr_pkg::KIND_PRESS) ||
                  (in_data.kind == bsr_pkg::KIND_RELEASE) ||
                  (in_data.kind == bsr_pkg::KIND_MOVE);

  always_comb begin
    pen_new = pen_r;
    if (in_data.kind == bsr_pkg::KIND_PRESS) pen_new = 1'b1;
    if (in_data.kind == bsr_pkg::KIND_RELEASE) pen_new = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r          <= 1'b0;
      anchor_valid_r <= 1'b0;
      anchor_x_r     <= '0;
      anchor_y_r     <= '0;
    end else if (cmd.accept && is_ptr) begin
      pen_r          <= pen_new;
      anchor_valid_r <= cmd.stamp && pen_new;
      if (cmd.stamp) begin
        anchor_x_r <= in_x;
        anchor_y_r <= in_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ev_x_r     <= in_x;
      ev_y_r     <= in_y;
      r_r        <= r_eff;
      line_req_r <= anchor_valid_r && cmd.stamp;
      rdv_r      <= (in_data.kind == bsr_pkg::KIND_READ) && in_inside;
      dx_r <= $signed({1'b0, DW'(in_x)}) - $signed({1'b0, DW'(anchor_x_r)});
      dy_r <= $signed({1'b0, DW'(in_y)}) - $signed({1'b0, DW'(anchor_y_r)});
      case (in_data.kind)
        bsr_pkg::KIND_PRESS:   code_r <= bsr_pkg::EV_STARTED;
        bsr_pkg::KIND_RELEASE: code_r <= bsr_pkg::EV_STOPPED;
        bsr_pkg::KIND_MOVE:    code_r <= pen_r ? bsr_pkg::EV_DRAWN : bsr_pkg::EV_NONE;
        default:               code_r <= bsr_pkg::EV_NONE;
      endcase
    end
  end

  // Bounding box
  logic          bvalid_r;
  logic [BW-1:0] lo_x_r, lo_y_r, hi_x_r, hi_y_r;
  logic signed [12:0] xs, ys, rs, lox0, loy0, hix0, hiy0, vlx, vly, vhx, vhy;

  always_comb begin
    xs   = 13'(in_data.pos_x);
    ys   = 13'(in_data.pos_y);
    rs   = $signed({7'b0, r_eff});
    lox0 = bvalid_r ? $signed({1'b0, 12'(lo_x_r)}) : 13'(W);
    loy0 = bvalid_r ? $signed({1'b0, 12'(lo_y_r)}) : 13'(H);
    hix0 = bvalid_r ? $signed({1'b0, 12'(hi_x_r)}) : 13'sd0;
    hiy0 = bvalid_r ? $signed({1'b0, 12'(hi_y_r)}) : 13'sd0;
    vlx  = (xs - rs < lox0) ? xs - rs : lox0;
    vly  = (ys - rs < loy0) ? ys - rs : loy0;
    vhx  = (xs + rs > hix0) ? xs + rs : hix0;
    vhy  = (ys + rs > hiy0) ? ys + rs : hiy0;
    if (vlx < 0) vlx = '0;
    if (vly < 0) vly = '0;
    if (vhx > 13'(W)) vhx = 13'(W);
    if (vhy > 13'(H)) vhy = 13'(H);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      lo_x_r   <= '0;
      lo_y_r   <= '0;
      hi_x_r   <= '0;
      hi_y_r   <= '0;
    end else if (cmd.accept && (in_data.kind == bsr_pkg::KIND_CLEAR)) begin
      bvalid_r <= 1'b0;
      lo_x_r   <= '0;
      lo_y_r   <= '0;
      hi_x_r   <= '0;
      hi_y_r   <= '0;
    end else if (cmd.stamp) begin
      bvalid_r <= 1'b1;
      lo_x_r   <= BW'(vlx);
      lo_y_r   <= BW'(vly);
      hi_x_r   <= BW'(vhx);
      hi_y_r   <= BW'(vhy);
    end
  end

  // Squared length
  logic [L2W-1:0] l2_r;
  logic signed [2*DW+1:0] sq_sum;
  assign sq_sum = dx_r * dx_r + dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_l2) l2_r <= sq_sum[L2W-1:0];
  end

  // Shared iteration counter
  logic [ITW-1:0] it_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (cmd.sq_start) begin
      it_r <= ITW'(LQW - 1);
    end else if (cmd.div_start) begin
      it_r <= ITW'(NW - 1);
    end else if ((cmd.sq_step || cmd.div_step) && (it_r != '0)) begin
      it_r <= it_r - 1'b1;
    end
  end

  // Square root of l2 * 2^32, one bit pair per cycle
  logic [SW-1:0] sv_r, sr_r, sb_r, s_sum;
  assign s_sum = sr_r + sb_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sv_r <= SW'({l2_r, 32'b0});
      sr_r <= '0;
      sb_r <= SW'(1) << (SW - 2);
    end else if (cmd.sq_step) begin
      if (sv_r >= s_sum) begin
        sv_r <= sv_r - s_sum;
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
  end

  logic [LQW-1:0] lq;
  assign lq = sr_r[LQW-1:0];

  // Rounded restoring divider for the unit vector
  logic [NW-1:0]  dv_r, quo_r, q_full;
  logic [LQW-1:0] rem_r;
  logic [LQW:0]   shifted;
  logic           qbit, neg_r;
  logic [DW-1:0]  mag;
  logic signed [DW:0] dsel;
  logic signed [NVW-1:0] nx_r, ny_r, n_val;

  assign dsel    = cmd.div_sel ? dy_r : dx_r;
  assign mag     = dsel[DW] ? DW'(-dsel) : DW'(dsel);
  assign shifted = {rem_r, dv_r[NW-1]};
  assign qbit    = (shifted >= {1'b0, lq});
  assign q_full  = {quo_r[NW-2:0], qbit};
  assign n_val   = neg_r ? -$signed({1'b0, q_full[NVW-2:0]})
                         :  $signed({1'b0, q_full[NVW-2:0]});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_r  <= NW'({mag, 32'b0}) + NW'(lq >> 1);
      rem_r <= '0;
      quo_r <= '0;
      neg_r <= dsel[DW];
    end else if (cmd.div_step) begin
      rem_r <= qbit ? LQW'(shifted - {1'b0, lq}) : shifted[LQW-1:0];
      dv_r  <= dv_r << 1;
      quo_r <= q_full;
      if (it_r == '0) begin
        if (cmd.div_sel) ny_r <= n_val;
        else             nx_r <= n_val;
      end
    end
  end

  // Line walker: rows across the stroke, steps along it
  logic signed [PW-1:0] rx_r, ry_r, px_r, py_r;
  logic [MW-1:0]        m_r;
  logic [L2W:0]         msq_r;
  logic [6:0]           rc_r;
  logic signed [DW:0]   basx, basy;
  logic signed [7:0]    jst;
  logic signed [27:0]   jny, jnx;

  assign basx = $signed({1'b0, DW'(ev_x_r)}) - dx_r;
  assign basy = $signed({1'b0, DW'(ev_y_r)}) - dy_r;
  assign jst  = $signed({2'b0, r_r - 6'd1});
  assign jny  = jst * ny_r;
  assign jnx  = jst * nx_r;

  always_ff @(posedge clk) begin
    if (cmd.line_setup) begin
      rx_r <= (PW'(basx) <<< 16) + PW'(jny);
      ry_r <= (PW'(basy) <<< 16) - PW'(jnx);
      rc_r <= 7'({r_r, 1'b0}) - 7'd2;
    end else if (cmd.row_next) begin
      rx_r <= rx_r - PW'(ny_r);
      ry_r <= ry_r + PW'(nx_r);
      rc_r <= rc_r - 7'd1;
    end
    if (cmd.row_start) begin
      px_r  <= rx_r + PW'(nx_r);
      py_r  <= ry_r + PW'(ny_r);
      m_r   <= MW'(1);
      msq_r <= (L2W + 1)'(1);
    end else if (cmd.line_step) begin
      px_r  <= px_r + PW'(nx_r);
      py_r  <= py_r + PW'(ny_r);
      m_r   <= m_r + 1'b1;
      msq_r <= msq_r + (L2W + 1)'({m_r, 1'b0}) + 1'b1;
    end
  end

  logic line_ok;
  assign line_ok = !px_r[PW-1] && !py_r[PW-1] && (px_r < XLIM) && (py_r < YLIM);

  // Disc walker
  logic signed [7:0]  dxo_r, dyo_r, rneg;
  logic signed [15:0] dxq, dyq;
  logic [11:0]        rsq;
  logic signed [12:0] cx, cy;
  logic               disc_ok;

  assign rneg = -$signed({2'b0, r_r});
  assign dxq  = dxo_r * dxo_r;
  assign dyq  = dyo_r * dyo_r;
  assign rsq  = r_r * r_r;
  assign cx   = $signed({1'b0, 12'(ev_x_r)}) + 13'(dxo_r);
  assign cy   = $signed({1'b0, 12'(ev_y_r)}) + 13'(dyo_r);
  assign disc_ok = (16'(dxq + dyq) <= 16'(rsq)) &&
                   (cx >= 0) && (cx < 13'(W)) && (cy >= 0) && (cy < 13'(H));

  always_ff @(posedge clk) begin
    if (cmd.disc_init) begin
      dxo_r <= rneg;
      dyo_r <= rneg;
    end else if (cmd.disc_step) begin
      if (dxo_r == $signed({2'b0, r_r})) begin
        dxo_r <= rneg;
        dyo_r <= dyo_r + 8'sd1;
      end else begin
        dxo_r <= dxo_r + 8'sd1;
      end
    end
  end

  // Canvas: colour with painted bit on top
  logic [32:0]   mem [DEPTH];
  logic [32:0]   rd_r;
  logic [AW-1:0] clr_r, addr, waddr;
  logic [XW-1:0] wx;
  logic [YW-1:0] wy;
  logic          we;
  logic [32:0]   wdata;

  always_comb begin
    wx = ev_x_r;
    wy = ev_y_r;
    if (cmd.line_step) begin
      wx = px_r[16+XW-1:16];
      wy = py_r[16+YW-1:16];
    end else if (cmd.disc_step) begin
      wx = cx[XW-1:0];
      wy = cy[YW-1:0];
    end
  end

  assign addr  = AW'(wy) * AW'(W) + AW'(wx);
  assign waddr = cmd.clr_step ? clr_r : addr;
  assign we    = cmd.clr_step || (cmd.line_step && line_ok) || (cmd.disc_step && disc_ok);
  assign wdata = cmd.clr_step ? {1'b0, bsr_pkg::BLANK_COLOUR} : {1'b1, colour_r};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= (clr_r == AW'(DEPTH - 1)) ? '0 : clr_r + 1'b1;
    end
  end

  // Status
  always_comb begin
    st.in_inside = in_inside;
    st.pen       = pen_r;
    st.line_go   = line_req_r && (l2_r != '0) && (r_r != '0);
    st.it_last   = (it_r == '0);
    st.row_end   = (msq_r >= (L2W + 1)'(l2_r));
    st.row_last  = (rc_r == '0);
    st.disc_last = (dxo_r == $signed({2'b0, r_r})) && (dyo_r == $signed({2'b0, r_r}));
    st.clr_last  = (clr_r == AW'(DEPTH - 1));
  end

  // Result
  always_comb begin
    out_data.event_code   = code_r;
    out_data.pixel_colour = rdv_r ? rd_r[31:0] : 32'd0;
    out_data.pixel_marked = rdv_r ? rd_r[32] : 1'b0;
    out_data.box_valid    = bvalid_r;
    out_data.box_min_x    = bvalid_r ? 9'(lo_x_r) : 9'd0;
    out_data.box_min_y    = bvalid_r ? 9'(lo_y_r) : 9'd0;
    out_data.box_max_x    = bvalid_r ? 9'(hi_x_r) : 9'd0;
    out_data.box_max_y    = bvalid_r ? 9'(hi_y_r) : 9'd0;
  end

endmodule

/* sv/brush_stroke_rasterizer.sv */
// Top level of the brush stroke rasterizer: sequencer plus datapath.
// Depends on bsr_pkg, bsr_ctrl and bsr_dp.
//
// One command is taken when start is high and busy is low; exactly one result
// follows on out_data, flagged by out_valid for a single cycle, and it cannot be
// held off. After reset the canvas is swept to blank with busy high; a clear
// sweeps it again before its result, which is flagged while busy is still
// high. A pixel read, an ignored kind, an off-canvas pointer or a pen-up move
// draws nothing. A stamp walks the disc one pixel per cycle through the single
// canvas write port; with a held anchor it first runs the square root and the
// two divisions for the unit vector, then walks the line as 2r-1 rows of steps
// along it.
module brush_stroke_rasterizer #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 256,
  parameter int MAX_RADIUS    = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bsr_pkg::in_item_t   in_data,
  output logic                out_valid,
  output bsr_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);

  bsr_pkg::cmd_t    cmd;
  bsr_pkg::status_t st;

  bsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_data.kind),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bsr_dp #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT),
    .MAX_RADIUS    (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

/* sv/bsr_checker.sv */
// Port-level checks of the brush stroke rasterizer, bound to the top level.
// Depends on bsr_pkg.
module bsr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input bsr_pkg::in_item_t  in_data,
  input logic               out_valid,
  input bsr_pkg::out_item_t out_data,
  input logic               cfg_we,
  input logic               cfg_index,
  input logic [31:0]        cfg_wdata
);

  // A result always belongs to a transaction still in flight.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction left no work");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");

  a_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.box_valid) |->
      (out_data.box_min_x == 9'd0 && out_data.box_min_y == 9'd0 &&
       out_data.box_max_x == 9'd0 && out_data.box_max_y == 9'd0))
    else $error("box shown without valid");

  a_pixel_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_code != bsr_pkg::EV_NONE) |->
      (out_data.pixel_colour == 32'd0 && !out_data.pixel_marked))
    else $error("pixel data on a pointer result");

endmodule

bind brush_stroke_rasterizer bsr_checker u_chk (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for brush_stroke_rasterizer: drives pointer, read and clear
// transactions, predicts every result with an internal canvas model and compares.
// Depends on bsr_pkg and the brush_stroke_rasterizer RTL.
module tb_top;

  localparam int W = 256;
  localparam int H = 256;
  localparam int STALL_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  bsr_pkg::in_item_t in_data = '0;
  logic out_valid;
  bsr_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  brush_stroke_rasterizer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [5:0] radius_q;
  logic [31:0] paint_q;
  logic pen_q, anc_ok;
  int anc_x, anc_y;
  logic box_ok;
  int lo_x, lo_y, hi_x, hi_y;
  logic [31:0] canvas_q [W*H];
  bit marked_q [W*H];

  bsr_pkg::in_item_t pending_cmds [$];
  bsr_pkg::out_item_t awaited_results [$];
  int mismatches = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit driver_on = 1'b0;
  bit no_idle = 1'b0;
  bit took = 1'b0;

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < W && y >= 0 && y < H;
  endfunction

  function automatic void put_pixel(int x, int y);
    if (on_canvas(x, y)) begin
      canvas_q[y*W+x] = paint_q;
      marked_q[y*W+x] = 1'b1;
    end
  endfunction

  function automatic void blank_canvas();
    foreach (canvas_q[i]) canvas_q[i] = bsr_pkg::BLANK_COLOUR;
    foreach (marked_q[i]) marked_q[i] = 1'b0;
    box_ok = 1'b0;
    lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(int d, longint unsigned lq);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 32) + lq / 2) / lq;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void sweep(int x, int y, int r);
    int dx, dy;
    longint l2, nx, ny, bx, by, px, py;
    longint unsigned lq;
    dx = x - anc_x;
    dy = y - anc_y;
    l2 = longint'(dx) * dx + longint'(dy) * dy;
    if (l2 == 0) return;
    lq = root64(longint'(l2) << 32);
    nx = unit_comp(dx, lq);
    ny = unit_comp(dy, lq);
    bx = longint'(anc_x) * 65536;
    by = longint'(anc_y) * 65536;
    for (longint j = r - 1; j >= 1 - r; j--) begin
      for (longint m = 1; m * m < l2; m++) begin
        px = bx + m * nx + j * ny;
        py = by + m * ny - j * nx;
        if (px >= 0 && py >= 0 && px < longint'(W) * 65536 && py < longint'(H) * 65536)
          put_pixel(int'(px >>> 16), int'(py >>> 16));
      end
    end
  endfunction

  function automatic void stamp_point(int x, int y);
    int r;
    r = (radius_q > 63) ? 63 : radius_q;
    if (!on_canvas(x, y)) return;
    if (!box_ok) begin
      lo_x = W; lo_y = H; hi_x = 0; hi_y = 0;
      box_ok = 1'b1;
    end
    lo_x = (x - r < lo_x) ? x - r : lo_x;  if (lo_x < 0) lo_x = 0;
    lo_y = (y - r < lo_y) ? y - r : lo_y;  if (lo_y < 0) lo_y = 0;
    hi_x = (x + r > hi_x) ? x + r : hi_x;  if (hi_x > W) hi_x = W;
    hi_y = (y + r > hi_y) ? y + r : hi_y;  if (hi_y > H) hi_y = H;
    if (anc_ok) sweep(x, y, r);
    anc_ok = 1'b1;
    anc_x = x;
    anc_y = y;
    for (int ddy = -r; ddy <= r; ddy++)
      for (int ddx = -r; ddx <= r; ddx++)
        if (ddx * ddx + ddy * ddy <= r * r) put_pixel(x + ddx, y + ddy);
  endfunction

  function automatic bsr_pkg::out_item_t predict_result(bsr_pkg::in_item_t c);
    bsr_pkg::out_item_t o;
    int x, y;
    o = '0;
    x = c.pos_x;
    y = c.pos_y;
    case (c.kind)
      bsr_pkg::KIND_PRESS: begin
        pen_q = 1'b1;
        o.event_code = bsr_pkg::EV_STARTED;
        stamp_point(x, y);
      end
      bsr_pkg::KIND_RELEASE: begin
        pen_q = 1'b0;
        o.event_code = bsr_pkg::EV_STOPPED;
        stamp_point(x, y);
      end
      bsr_pkg::KIND_MOVE: begin
        if (pen_q) begin
          stamp_point(x, y);
          o.event_code = bsr_pkg::EV_DRAWN;
        end
      end
      bsr_pkg::KIND_READ: begin
        if (on_canvas(x, y)) begin
          o.pixel_colour = canvas_q[y*W+x];
          o.pixel_marked = marked_q[y*W+x];
        end
      end
      bsr_pkg::KIND_CLEAR: blank_canvas();
      default: ;
    endcase
    if (c.kind == bsr_pkg::KIND_PRESS || c.kind == bsr_pkg::KIND_RELEASE ||
        c.kind == bsr_pkg::KIND_MOVE)
      if (!pen_q || !on_canvas(x, y)) anc_ok = 1'b0;
    o.box_valid = box_ok;
    if (box_ok) begin
      o.box_min_x = lo_x[8:0]; o.box_min_y = lo_y[8:0];
      o.box_max_x = hi_x[8:0]; o.box_max_y = hi_y[8:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, what, got, want);
  endtask

  // Driver: changes inputs on the falling edge; a transaction stays put until taken.
  always @(negedge clk) begin
    if (start && !took) begin
      start <= 1'b1;
    end else if (driver_on && pending_cmds.size() > 0 &&
                 (no_idle || $urandom_range(99) >= 38)) begin
      in_data <= pending_cmds.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    took = start && !busy;
    if (took) begin
      awaited_results.push_back(predict_result(in_data));
      cmds_sent++;
    end
    if (out_valid) begin
      results_seen++;
      quiet_cycles <= 0;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("MISMATCH unexpected result %0d", results_seen);
      end else begin
        bsr_pkg::out_item_t e;
        e = awaited_results.pop_front();
        if (out_data.event_code !== e.event_code)
          report_mismatch("event_code", 32'(out_data.event_code), 32'(e.event_code));
        if (out_data.pixel_colour !== e.pixel_colour)
          report_mismatch("pixel_colour", out_data.pixel_colour, e.pixel_colour);
        if (out_data.pixel_marked !== e.pixel_marked)
          report_mismatch("pixel_marked", 32'(out_data.pixel_marked), 32'(e.pixel_marked));
        if (out_data.box_valid !== e.box_valid)
          report_mismatch("box_valid", 32'(out_data.box_valid), 32'(e.box_valid));
        if (out_data.box_min_x !== e.box_min_x)
          report_mismatch("box_min_x", 32'(out_data.box_min_x), 32'(e.box_min_x));
        if (out_data.box_min_y !== e.box_min_y)
          report_mismatch("box_min_y", 32'(out_data.box_min_y), 32'(e.box_min_y));
        if (out_data.box_max_x !== e.box_max_x)
          report_mismatch("box_max_x", 32'(out_data.box_max_x), 32'(e.box_max_x));
        if (out_data.box_max_y !== e.box_max_y)
          report_mismatch("box_max_y", 32'(out_data.box_max_y), 32'(e.box_max_y));
      end
    end else if (took) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bsr_pkg::in_item_t make_cmd(logic [2:0] k, int x, int y);
    bsr_pkg::in_item_t c;
    c.kind = k;
    c.pos_x = x[11:0];
    c.pos_y = y[11:0];
    return c;
  endfunction

  // Mostly strokes near the canvas; some noise anywhere in the field range.
  function automatic bsr_pkg::in_item_t random_cmd();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8)
      return make_cmd(3'($urandom_range(7)), $urandom_range(4095), $urandom_range(4095));
    else if (sel < 30)
      return make_cmd(bsr_pkg::KIND_READ, $urandom_range(270) - 8, $urandom_range(270) - 8);
    else if (sel < 32)
      return make_cmd(bsr_pkg::KIND_CLEAR, $urandom_range(4095), $urandom_range(4095));
    else
      return make_cmd(3'($urandom_range(2)), $urandom_range(280) - 12,
                      $urandom_range(280) - 12);
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bsr_pkg::CFG_RADIUS) radius_q = val[5:0];
    else paint_q = val;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || start || awaited_results.size() > 0 || busy)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
    drain();
  endtask

  initial begin
    radius_q = bsr_pkg::RADIUS_RESET;
    paint_q = bsr_pkg::COLOUR_RESET;
    pen_q = 1'b0; anc_ok = 1'b0; anc_x = 0; anc_y = 0;
    blank_canvas();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    driver_on = 1'b1;

    // Directed: reset radius, field extremes, every defined kind, edge cases.
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 10, 10));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, 20, 20));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_PRESS, 0, 0));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, 30, 5));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, 30, 5));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, -2048, 2047));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, 255, 255));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_RELEASE, 250, 200));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 0, 0));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 255, 255));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 2047, -2048));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 128, 128));
    pending_cmds.push_back(make_cmd(3'd5, 1, 1));
    pending_cmds.push_back(make_cmd(3'd7, -1, -1));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_CLEAR, 0, 0));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 0, 0));
    drain();

    // Radius extremes and the colour register; the sender pauses in drain().
    write_reg(bsr_pkg::CFG_RADIUS, 32'd0);
    write_reg(bsr_pkg::CFG_COLOUR, 32'hFFFF_FFFF);
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_PRESS, 100, 100));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, 140, 110));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 120, 105));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_RELEASE, 100, 100));
    drain();
    write_reg(bsr_pkg::CFG_RADIUS, 32'd63);
    write_reg(bsr_pkg::CFG_COLOUR, 32'h0000_0000);
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_PRESS, 5, 250));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_MOVE, 60, 200));
    pending_cmds.push_back(make_cmd(bsr_pkg::KIND_READ, 5, 250));
    drain();

    write_reg(bsr_pkg::CFG_RADIUS, 32'd3);
    write_reg(bsr_pkg::CFG_COLOUR, $urandom);
    run_phase(30);
    no_idle = 1'b1;
    write_reg(bsr_pkg::CFG_RADIUS, $urandom_range(8));
    write_reg(bsr_pkg::CFG_COLOUR, $urandom);
    run_phase(25);
    no_idle = 1'b0;
    write_reg(bsr_pkg::CFG_RADIUS, $urandom_range(12));
    write_reg(bsr_pkg::CFG_COLOUR, $urandom);
    run_phase(25);

    $display("Ran %0d transactions through press/release/move strokes, reads, clears", cmds_sent);
    $display("and ignored kinds, across radius settings 0 to 63 and several colours.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bsr_pkg.sv
sv/bsr_ctrl.sv
sv/bsr_dp.sv
sv/brush_stroke_rasterizer.sv
sv/bsr_checker.sv
tb/tb_top.sv
